// File: src/battery_voltage_averager_core_assert.svh
// Assertion macros used by the checker file of the averager core.
`ifndef BATTERY_VOLTAGE_AVERAGER_CORE_ASSERT_SVH
`define BATTERY_VOLTAGE_AVERAGER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define BVA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("averager check failed");

// Next-cycle implication, disabled while rst is high.
`define BVA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("averager check failed");

`endif

// File: src/bva_pkg.sv
package bva_pkg;

   // Channel and window geometry
   localparam int CHANNELS = 2;
   localparam int WINDOW   = 10;

   // Field widths
   localparam int CH_W      = 1;
   localparam int MV_W      = 16;
   localparam int DV_W      = 10;
   localparam int LIMIT_W   = 10;
   localparam int CSR_IDX_W = 4;

   // Largest sample in decivolts and the running sum width that holds a full window
   localparam int DV_MAX = 655;
   localparam int SUM_W  = $clog2(WINDOW * DV_MAX + 1);

   // Rounding to decivolts: (mv + 50) / 100 through a scaled reciprocal
   localparam int RECIP_SHIFT = 24;
   localparam int DV_ROUND    = 50;
   localparam int DV_DIV      = 100;
   localparam int DV_MUL      = (2**RECIP_SHIFT + DV_DIV - 1) / DV_DIV;
   localparam int DV_MUL_W    = $clog2(DV_MUL + 1);
   localparam int MVR_W       = MV_W + 1;
   localparam int DV_PROD_W   = MVR_W + DV_MUL_W;

   // Rounded average: (sum + WINDOW/2) / WINDOW through a scaled reciprocal
   localparam int AVG_ROUND  = WINDOW / 2;
   localparam int AVG_MUL    = (2**RECIP_SHIFT + WINDOW - 1) / WINDOW;
   localparam int AVG_MUL_W  = $clog2(AVG_MUL + 1);
   localparam int SUMR_W     = $clog2(WINDOW * DV_MAX + AVG_ROUND + 1);
   localparam int AVG_PROD_W = SUMR_W + AVG_MUL_W;

   // Configuration register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_LIMIT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MID_LIMIT = CSR_IDX_W'(1);
   localparam logic [LIMIT_W-1:0]   LOW_LIMIT_RST = LIMIT_W'(148);
   localparam logic [LIMIT_W-1:0]   MID_LIMIT_RST = LIMIT_W'(158);

   // Charge class
   typedef enum logic [1:0] {
      LEVEL_LOW  = 2'd0,
      LEVEL_MID  = 2'd1,
      LEVEL_GOOD = 2'd2
   } level_type;

   // Control handed from the core to one channel row
   typedef struct packed {
      logic            shift;
      logic [DV_W-1:0] dv;
   } row_ctl_type;

endpackage

// File: src/battery_voltage_averager_core.sv
// Battery voltage averager core.
// Request channel: req_valid / req_stall with req_channel and req_voltage_mv.
// A sample transfers at a clock edge with req_valid high and req_stall low.
// Response channel: rsp_valid / rsp_stall with rsp_out_channel,
// rsp_average_dv, rsp_level and rsp_changed; one response per sample.
// Config channel: csr_valid / csr_ready with csr_index and csr_wdata;
// index 0 is the low limit, 1 the mid limit, other indexes are dropped.
// csr_ready is always high; write limits only while the core is idle.
// Each sample goes through stages 1, 2, 3 and then the output stage.
// Throughput: one sample per cycle while req_stall is low; each row
// of cells and its running sum update together as a sample enters
// stage 2, so back-to-back samples on one channel need no forwarding.
// Reset clears every sample cell, running sum, last-shown average and the
// pipeline; the limits return to 148 and 158 decivolts.
// When rsp_stall holds a response, earlier stages keep filling any empty
// slots, and req_stall rises only once every stage holds a sample.
module battery_voltage_averager_core (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bva_pkg::CH_W-1:0]      req_channel,
   input  logic [bva_pkg::MV_W-1:0]      req_voltage_mv,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bva_pkg::CH_W-1:0]      rsp_out_channel,
   output logic [bva_pkg::DV_W-1:0]      rsp_average_dv,
   output logic [1:0]                    rsp_level,
   output logic                          rsp_changed,
   // configuration channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bva_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bva_pkg::LIMIT_W-1:0]   csr_wdata
);
   import bva_pkg::*;

   // Limit registers
   logic [LIMIT_W-1:0] low_limit_ff;
   logic [LIMIT_W-1:0] mid_limit_ff;

   // Stage enables
   logic out_en, s3_en, s2_en, s1_en;
   logic req_take, in_range;

   // Stage 1: sample rounded to decivolts
   logic               s1_v_ff, s1_v_in;
   logic [CH_W-1:0]    s1_ch_ff;
   logic [DV_W-1:0]    s1_dv_ff;
   logic [DV_PROD_W-1:0] dv_prod;

   // Stage 2: updated running sum
   logic               s2_v_ff;
   logic [CH_W-1:0]    s2_ch_ff;
   logic [SUM_W-1:0]   s2_sum_ff;
   logic [SUM_W-1:0]   row_sum [CHANNELS];
   logic [SUM_W-1:0]   sel_sum;

   // Stage 3: rounded average
   logic               s3_v_ff;
   logic [CH_W-1:0]    s3_ch_ff;
   logic [DV_W-1:0]    s3_avg_ff;
   logic [AVG_PROD_W-1:0] avg_prod;

   // Output stage and per-channel display history
   logic               rsp_valid_ff;
   logic [CH_W-1:0]    out_ch_ff;
   logic [DV_W-1:0]    out_avg_ff;
   level_type          out_level_ff;
   level_type          level_calc;
   logic               out_chg_ff;
   logic [DV_W-1:0]    last_shown_ff [CHANNELS];
   logic               shown_valid_ff [CHANNELS];
   logic [DV_W-1:0]    last_sel;
   logic               shown_sel;
   logic               chg_calc;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff <= LOW_LIMIT_RST;
         mid_limit_ff <= MID_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_LOW_LIMIT) begin
            low_limit_ff <= csr_wdata;
         end
         if (csr_index == CSR_MID_LIMIT) begin
            mid_limit_ff <= csr_wdata;
         end
      end
   end

   // A stage moves when it is empty or the next one moves
   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign s3_en     = !s3_v_ff || out_en;
   assign s2_en     = !s2_v_ff || s3_en;
   assign s1_en     = !s1_v_ff || s2_en;
   assign req_stall = !s1_en;
   assign req_take  = req_valid && s1_en;
   assign in_range  = int'(req_channel) < CHANNELS;

   // Stage 1: (mv + 50) / 100 by reciprocal multiply
   assign dv_prod = DV_PROD_W'(MVR_W'(req_voltage_mv) + MVR_W'(DV_ROUND))
                  * DV_PROD_W'(DV_MUL);
   assign s1_v_in = req_take && in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_en) begin
         s1_v_ff <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_in) begin
         s1_ch_ff <= req_channel;
         s1_dv_ff <= dv_prod[RECIP_SHIFT +: DV_W];
      end
   end

   // Stage 2: one row of cells per channel
   for (genvar c = 0; c < CHANNELS; c++) begin : g_row
      row_ctl_type ctl;
      assign ctl.shift = s2_en && s1_v_ff && (s1_ch_ff == CH_W'(c));
      assign ctl.dv    = s1_dv_ff;
      bva_row u_row (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .sum_new (row_sum[c])
      );
   end

   always_comb begin
      sel_sum = row_sum[0];
      for (int c = 1; c < CHANNELS; c++) begin
         if (s1_ch_ff == CH_W'(c)) begin
            sel_sum = row_sum[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_en) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en && s1_v_ff) begin
         s2_ch_ff  <= s1_ch_ff;
         s2_sum_ff <= sel_sum;
      end
   end

   // Stage 3: (sum + WINDOW/2) / WINDOW by reciprocal multiply
   assign avg_prod = AVG_PROD_W'(SUMR_W'(s2_sum_ff) + SUMR_W'(AVG_ROUND))
                   * AVG_PROD_W'(AVG_MUL);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (s3_en) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en && s2_v_ff) begin
         s3_ch_ff  <= s2_ch_ff;
         s3_avg_ff <= avg_prod[RECIP_SHIFT +: DV_W];
      end
   end

   // Output stage: class against limits, compare with last shown value
   always_comb begin
      last_sel  = last_shown_ff[0];
      shown_sel = shown_valid_ff[0];
      for (int c = 1; c < CHANNELS; c++) begin
         if (s3_ch_ff == CH_W'(c)) begin
            last_sel  = last_shown_ff[c];
            shown_sel = shown_valid_ff[c];
         end
      end
   end

   assign chg_calc = !shown_sel || (last_sel != s3_avg_ff);

   always_comb begin
      priority if (s3_avg_ff <= low_limit_ff) begin
         level_calc = LEVEL_LOW;
      end else if (s3_avg_ff <= mid_limit_ff) begin
         level_calc = LEVEL_MID;
      end else begin
         level_calc = LEVEL_GOOD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            last_shown_ff[c]  <= '0;
            shown_valid_ff[c] <= 1'b0;
         end
      end else if (out_en) begin
         rsp_valid_ff <= s3_v_ff;
         for (int c = 0; c < CHANNELS; c++) begin
            if (s3_v_ff && (s3_ch_ff == CH_W'(c))) begin
               last_shown_ff[c]  <= s3_avg_ff;
               shown_valid_ff[c] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && s3_v_ff) begin
         out_ch_ff    <= s3_ch_ff;
         out_avg_ff   <= s3_avg_ff;
         out_level_ff <= level_calc;
         out_chg_ff   <= chg_calc;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = out_ch_ff;
   assign rsp_average_dv  = out_avg_ff;
   assign rsp_level       = out_level_ff;
   assign rsp_changed     = out_chg_ff;

endmodule

// File: src/bva_cell.sv
module bva_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     shift,
   input  logic [bva_pkg::DV_W-1:0] din,
   output logic [bva_pkg::DV_W-1:0] dout
);
   import bva_pkg::*;

   logic [DV_W-1:0] sample_ff;
   logic [DV_W-1:0] sample_in;

   // Take the neighbor's sample on a shift
   assign sample_in = shift ? din : sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in;
      end
   end

   assign dout = sample_ff;

endmodule

// File: src/bva_row.sv
module bva_row (
   input  logic                      clock,
   input  logic                      reset,
   input  bva_pkg::row_ctl_type      ctl,
   output logic [bva_pkg::SUM_W-1:0] sum_new
);
   import bva_pkg::*;

   logic [DV_W-1:0]  tap [WINDOW];
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;

   // Chain of sample cells: newest enters cell 0, oldest leaves the last cell
   for (genvar k = 0; k < WINDOW; k++) begin : g_cell
      if (k == 0) begin : g_head
         bva_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (ctl.shift),
            .din   (ctl.dv),
            .dout  (tap[k])
         );
      end else begin : g_body
         bva_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (ctl.shift),
            .din   (tap[k-1]),
            .dout  (tap[k])
         );
      end
   end

   // Running sum: drop the oldest sample, add the newest
   assign sum_new = sum_ff - SUM_W'(tap[WINDOW-1]) + SUM_W'(ctl.dv);
   assign sum_in  = ctl.shift ? sum_new : sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

// File: src/bva_checker.sv
`include "battery_voltage_averager_core_assert.svh"

module bva_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [bva_pkg::CH_W-1:0] rsp_out_channel,
   input logic [bva_pkg::DV_W-1:0] rsp_average_dv,
   input logic [1:0]               rsp_level,
   input logic                     rsp_changed
);
   import bva_pkg::*;

   // A held response keeps its channel, average and changed flag
   `BVA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_average_dv) && $stable(rsp_out_channel) && $stable(rsp_changed))

   // Class code never takes the unused value
   `BVA_ASSERT_IMPL(a_level_code, clock, reset, rsp_valid,
      rsp_level == LEVEL_LOW || rsp_level == LEVEL_MID || rsp_level == LEVEL_GOOD)

   // Pipeline is empty right after reset
   `BVA_ASSERT_IMPL(a_empty_after_reset, clock, 1'b0, $past(reset), rsp_valid !== 1'b1)

   // No response can have passed through stages 1 to 3 and the output stage since the reset the check looks back to
   `BVA_ASSERT_IMPL(a_latency_after_reset, clock, 1'b0, $past(reset, 3), rsp_valid !== 1'b1)

endmodule

bind battery_voltage_averager_core bva_checker u_bva_checker (.*);
